// ===== hdl/ucrh_pkg.sv =====
// Package for the USB control request handler: payload structs, codes,
// descriptor table and descriptor ROM. No dependencies.
`timescale 1ns / 1ps
package ucrh_pkg;

    typedef struct packed {
        logic        action;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] value_word;
        logic [15:0] index_word;
        logic [15:0] length_word;
        logic [55:0] out_payload;
        logic [47:0] key_report;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  handshake;
        logic [63:0] data_bytes;
        logic [3:0]  byte_count;
        logic        packet_end;
        logic        last;
        logic [6:0]  device_address;
        logic [7:0]  configuration_value;
    } t_out_item;

    localparam logic [1:0] HS_ACK   = 2'd0;
    localparam logic [1:0] HS_DATA  = 2'd1;
    localparam logic [1:0] HS_STALL = 2'd2;

    localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
    localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
    localparam logic [7:0] REQ_GET_IDLE      = 8'h02;
    localparam logic [7:0] REQ_SET_FEATURE   = 8'h03;
    localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
    localparam logic [7:0] REQ_GET_DESC      = 8'h06;
    localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
    localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
    localparam logic [7:0] REQ_SET_IDLE      = 8'h0A;
    localparam logic [7:0] REQ_SET_PROTOCOL  = 8'h0B;
    localparam logic [7:0] REQ_SET_LINE      = 8'h20;
    localparam logic [7:0] REQ_GET_LINE      = 8'h21;
    localparam logic [7:0] REQ_SET_CTRL      = 8'h22;

    localparam logic [7:0] TYPE_STD_DEV_OUT = 8'h00;
    localparam logic [7:0] TYPE_STD_EP_OUT  = 8'h02;
    localparam logic [7:0] TYPE_STD_DEV_IN  = 8'h80;
    localparam logic [7:0] TYPE_STD_EP_IN   = 8'h82;
    localparam logic [7:0] TYPE_CLASS_IN    = 8'hA1;
    localparam logic [7:0] TYPE_CLASS_OUT   = 8'h21;

    localparam logic [15:0] KBD_INTERFACE = 16'h0002;
    localparam logic [55:0] LINE_CODING_RESET = 56'h08000000E100;
    localparam logic [7:0]  IDLE_RESET = 8'd125;
    localparam int          ROM_BYTES = 227;
    localparam int          TABLE_SLOTS = 16;
    // Endpoint-zero packet size; it must stay a power of two.
    localparam int          EP0_PACKET_BYTES = 16;

    // Command handed from the decoder to the executor.
    typedef enum logic [1:0] {
        CMD_SINGLE = 2'd0,
        CMD_DESC   = 2'd1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [1:0]  handshake;
        logic [63:0] data_bytes;
        logic [3:0]  byte_count;
        logic [7:0]  desc_base;
        logic [7:0]  desc_len;
        logic [6:0]  device_address;
        logic [7:0]  configuration_value;
    } t_cmd;

    typedef enum logic [0:0] {
        EX_IDLE = 1'b0,
        EX_DESC = 1'b1
    } t_ex_state;

    typedef struct packed {
        logic [15:0] value;
        logic [15:0] index;
        logic [7:0]  offset;
        logic [7:0]  length;
    } t_desc_entry;

    function automatic t_desc_entry desc_entry(input logic [3:0] slot);
        unique case (slot)
            4'd0:    desc_entry = '{16'h0100, 16'h0000, 8'd0,   8'd18};
            4'd1:    desc_entry = '{16'h0200, 16'h0000, 8'd18,  8'd92};
            4'd2:    desc_entry = '{16'h2200, 16'h0002, 8'd110, 8'd63};
            4'd3:    desc_entry = '{16'h2100, 16'h0002, 8'd94,  8'd9};
            4'd4:    desc_entry = '{16'h0300, 16'h0000, 8'd173, 8'd4};
            4'd5:    desc_entry = '{16'h0301, 16'h0409, 8'd177, 8'd22};
            4'd6:    desc_entry = '{16'h0302, 16'h0409, 8'd199, 8'd24};
            4'd7:    desc_entry = '{16'h0303, 16'h0409, 8'd223, 8'd4};
            default: desc_entry = '{16'h0000, 16'h0000, 8'd0, 8'd0};
        endcase
    endfunction

    function automatic logic desc_present(input logic [3:0] slot);
        desc_present = (slot < 4'd8);
    endfunction

    localparam logic [7:0] ROM [0:ROM_BYTES-1] = '{
        8'd18, 8'd1, 8'h00, 8'h02, 8'd0, 8'd0, 8'd0, 8'(EP0_PACKET_BYTES),
        8'hC0, 8'h16, 8'h7A, 8'h04,
        8'h00, 8'h01, 8'd1, 8'd2, 8'd3, 8'd1,
        8'd9, 8'd2, 8'd92, 8'd0, 8'd3, 8'd1, 8'd0, 8'hC0, 8'd50,
        8'd9, 8'd4, 8'd0, 8'd0, 8'd1, 8'd2, 8'd2, 8'd1, 8'd0,
        8'd5, 8'h24, 8'd0, 8'h10, 8'h01,
        8'd5, 8'h24, 8'd1, 8'd1, 8'd1,
        8'd4, 8'h24, 8'd2, 8'd6,
        8'd5, 8'h24, 8'd6, 8'd0, 8'd1,
        8'd7, 8'd5, 8'h82, 8'd3, 8'd16, 8'd0, 8'd64,
        8'd9, 8'd4, 8'd1, 8'd0, 8'd2, 8'h0A, 8'd0, 8'd0, 8'd0,
        8'd7, 8'd5, 8'd3, 8'd2, 8'd16, 8'd0, 8'd0,
        8'd7, 8'd5, 8'h84, 8'd2, 8'd64, 8'd0, 8'd0,
        8'd9, 8'd4, 8'd2, 8'd0, 8'd1, 8'd3, 8'd1, 8'd1, 8'd0,
        8'd9, 8'h21, 8'h11, 8'h01, 8'd0, 8'd1, 8'h22, 8'd63, 8'd0,
        8'd7, 8'd5, 8'h81, 8'd3, 8'd8, 8'd0, 8'd1,
        8'h05, 8'h01, 8'h09, 8'h06, 8'hA1, 8'h01, 8'h75, 8'h01, 8'h95, 8'h08, 8'h05, 8'h07,
        8'h19, 8'hE0, 8'h29, 8'hE7, 8'h15, 8'h00, 8'h25, 8'h01, 8'h81, 8'h02, 8'h95, 8'h01,
        8'h75, 8'h08, 8'h81, 8'h03, 8'h95, 8'h05, 8'h75, 8'h01, 8'h05, 8'h08, 8'h19, 8'h01,
        8'h29, 8'h05, 8'h91, 8'h02, 8'h95, 8'h01, 8'h75, 8'h03, 8'h91, 8'h03, 8'h95, 8'h06,
        8'h75, 8'h08, 8'h15, 8'h00, 8'h25, 8'h68, 8'h05, 8'h07, 8'h19, 8'h00, 8'h29, 8'h68,
        8'h81, 8'h00, 8'hC0,
        8'd4, 8'd3, 8'h09, 8'h04,
        8'd22, 8'd3, 8'h44, 8'd0, 8'h65, 8'd0, 8'h6C, 8'd0, 8'h75, 8'd0, 8'h73, 8'd0,
        8'h69, 8'd0, 8'h6F, 8'd0, 8'h6E, 8'd0, 8'h61, 8'd0, 8'h6C, 8'd0,
        8'd24, 8'd3, 8'h53, 8'd0, 8'h63, 8'd0, 8'h72, 8'd0, 8'h65, 8'd0, 8'h65, 8'd0,
        8'h6E, 8'd0, 8'h54, 8'd0, 8'h69, 8'd0, 8'h6D, 8'd0, 8'h65, 8'd0, 8'h72, 8'd0,
        8'd4, 8'd3, 8'h31, 8'd0
    };

    function automatic logic [7:0] rom_byte(input logic [8:0] addr);
        if (addr < 9'(ROM_BYTES)) begin
            rom_byte = ROM[addr[7:0]];
        end else begin
            rom_byte = 8'h00;
        end
    endfunction

endpackage

// ===== hdl/usb_control_request_handler_top.sv =====
// Endpoint-zero request engine for a serial-plus-keyboard device. A request
// is decoded combinationally into a registered command; a descriptor read also walks
// the descriptor table one slot per cycle before the executor streams up to twelve
// 8-byte beats, one per cycle while the result queue has room. A one-entry
// command register between decoder and executor and a two-entry result queue
// let both sides stall independently. Key updates produce no result.
// Depends on ucrh_pkg, ucrh_decode, ucrh_execute.
`timescale 1ns / 1ps
module usb_control_request_handler_top #(
    parameter int NUM_ENDPOINTS    = 4,
    parameter int NUM_DESCRIPTORS  = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  ucrh_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output ucrh_pkg::t_out_item o_item
);

    logic           cmd_valid;
    logic           cmd_ready;
    ucrh_pkg::t_cmd cmd;
    logic           ready;

    assign full = !ready;

    ucrh_decode #(
        .NUM_ENDPOINTS  (NUM_ENDPOINTS),
        .NUM_DESCRIPTORS(NUM_DESCRIPTORS)
    ) u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (push),
        .i_item     (i_item),
        .o_ready    (ready),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_cmd_ready(cmd_ready)
    );

    ucrh_execute u_execute (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_cmd_ready(cmd_ready),
        .o_empty    (empty),
        .o_item     (o_item),
        .i_pop      (pop)
    );

endmodule

// ===== hdl/ucrh_decode.sv =====
// Front part: accepts requests, keeps all device state and turns each request
// other than a key update into one command for the executor. Depends on ucrh_pkg.
`timescale 1ns / 1ps
module ucrh_decode #(
    parameter int NUM_ENDPOINTS   = 4,
    parameter int NUM_DESCRIPTORS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ucrh_pkg::t_in_item i_item,
    output logic               o_ready,
    output logic               o_cmd_valid,
    output ucrh_pkg::t_cmd     o_cmd,
    input  logic               i_cmd_ready
);

    localparam int EP_W = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;

    logic [7:0]               r_config, n_config;
    logic [6:0]               r_addr, n_addr;
    logic [7:0]               r_ctrl, n_ctrl;
    logic [55:0]              r_line, n_line;
    logic [7:0]               r_idle, n_idle;
    logic [7:0]               r_proto, n_proto;
    logic [NUM_ENDPOINTS-1:0] r_halt, n_halt;
    logic [47:0]              r_keys, n_keys;

    // Descriptor lookup runs one slot per cycle.
    logic              r_busy;
    logic [4:0]        r_slot;
    ucrh_pkg::t_in_item r_req;
    logic              r_cmd_valid;
    ucrh_pkg::t_cmd    r_cmd;

    ucrh_pkg::t_cmd    n_cmd;
    logic              n_emit;
    logic [6:0]        ep;
    logic [EP_W-1:0]   ep_idx;
    logic              ep_ok;
    logic [63:0]       status;
    ucrh_pkg::t_desc_entry ent;
    logic [7:0]        clamp;
    logic [7:0]        dlen;

    assign o_ready     = !r_busy && (!r_cmd_valid || i_cmd_ready);
    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd       = r_cmd;

    assign ep     = i_item.index_word[6:0];
    assign ep_idx = EP_W'(ep - 7'd1);
    assign ep_ok  = (ep >= 7'd1) && (ep <= 7'(NUM_ENDPOINTS));
    assign ent    = ucrh_pkg::desc_entry(r_slot[3:0]);
    assign clamp  = (r_req.length_word > 16'd255) ? 8'd255 : r_req.length_word[7:0];
    assign dlen   = (ent.length < clamp) ? ent.length : clamp;

    always_comb begin
        n_config = r_config;
        n_addr   = r_addr;
        n_ctrl   = r_ctrl;
        n_line   = r_line;
        n_idle   = r_idle;
        n_proto  = r_proto;
        n_halt   = r_halt;
        n_keys   = r_keys;
        n_emit   = 1'b0;
        status   = '0;
        n_cmd    = '{kind: ucrh_pkg::CMD_SINGLE, handshake: ucrh_pkg::HS_STALL,
                     data_bytes: '0, byte_count: '0, desc_base: '0, desc_len: '0,
                     device_address: r_addr, configuration_value: r_config};
        if (i_valid && o_ready && i_item.action) begin
            n_keys = i_item.key_report;
        end else if (i_valid && o_ready && i_item.request_code != ucrh_pkg::REQ_GET_DESC) begin
            n_emit = 1'b1;
            if (i_item.request_code == ucrh_pkg::REQ_SET_ADDRESS) begin
                n_addr = i_item.value_word[6:0];
                n_cmd.handshake = ucrh_pkg::HS_ACK;
            end else if (i_item.request_code == ucrh_pkg::REQ_SET_CONFIG &&
                         i_item.request_type == ucrh_pkg::TYPE_STD_DEV_OUT) begin
                n_config = i_item.value_word[7:0];
                n_ctrl   = '0;
                n_halt   = '0;
                n_cmd.handshake = ucrh_pkg::HS_ACK;
            end else if (i_item.request_code == ucrh_pkg::REQ_GET_CONFIG &&
                         i_item.request_type == ucrh_pkg::TYPE_STD_DEV_IN) begin
                n_cmd.handshake = ucrh_pkg::HS_DATA;
                n_cmd.data_bytes = {56'd0, r_config};
                n_cmd.byte_count = 4'd1;
            end else if (i_item.request_code == ucrh_pkg::REQ_GET_LINE &&
                         i_item.request_type == ucrh_pkg::TYPE_CLASS_IN) begin
                n_cmd.handshake = ucrh_pkg::HS_DATA;
                n_cmd.data_bytes = {8'd0, r_line};
                n_cmd.byte_count = 4'd7;
            end else if (i_item.request_code == ucrh_pkg::REQ_SET_LINE &&
                         i_item.request_type == ucrh_pkg::TYPE_CLASS_OUT) begin
                n_line = i_item.out_payload;
                n_cmd.handshake = ucrh_pkg::HS_ACK;
            end else if (i_item.request_code == ucrh_pkg::REQ_SET_CTRL &&
                         i_item.request_type == ucrh_pkg::TYPE_CLASS_OUT) begin
                n_ctrl = i_item.value_word[7:0];
                n_cmd.handshake = ucrh_pkg::HS_ACK;
            end else if (i_item.request_code == ucrh_pkg::REQ_GET_STATUS) begin
                if (i_item.request_type == ucrh_pkg::TYPE_STD_EP_IN && ep_ok) begin
                    status[0] = r_halt[ep_idx];
                end
                n_cmd.handshake = ucrh_pkg::HS_DATA;
                n_cmd.data_bytes = status;
                n_cmd.byte_count = 4'd2;
            end else if ((i_item.request_code == ucrh_pkg::REQ_CLEAR_FEATURE ||
                          i_item.request_code == ucrh_pkg::REQ_SET_FEATURE) &&
                         i_item.request_type == ucrh_pkg::TYPE_STD_EP_OUT &&
                         i_item.value_word == 16'd0 && ep_ok) begin
                n_halt[ep_idx] = (i_item.request_code == ucrh_pkg::REQ_SET_FEATURE);
                n_cmd.handshake = ucrh_pkg::HS_ACK;
            end else if (i_item.index_word == ucrh_pkg::KBD_INTERFACE &&
                         i_item.request_type == ucrh_pkg::TYPE_CLASS_IN &&
                         (i_item.request_code == ucrh_pkg::REQ_CLEAR_FEATURE ||
                          i_item.request_code == ucrh_pkg::REQ_GET_IDLE ||
                          i_item.request_code == ucrh_pkg::REQ_SET_FEATURE)) begin
                n_cmd.handshake = ucrh_pkg::HS_DATA;
                if (i_item.request_code == ucrh_pkg::REQ_CLEAR_FEATURE) begin
                    n_cmd.data_bytes = {r_keys, 16'd0};
                    n_cmd.byte_count = 4'd8;
                end else if (i_item.request_code == ucrh_pkg::REQ_GET_IDLE) begin
                    n_cmd.data_bytes = {56'd0, r_idle};
                    n_cmd.byte_count = 4'd1;
                end else begin
                    n_cmd.data_bytes = {56'd0, r_proto};
                    n_cmd.byte_count = 4'd1;
                end
            end else if (i_item.index_word == ucrh_pkg::KBD_INTERFACE &&
                         i_item.request_type == ucrh_pkg::TYPE_CLASS_OUT &&
                         (i_item.request_code == ucrh_pkg::REQ_SET_CONFIG ||
                          i_item.request_code == ucrh_pkg::REQ_SET_IDLE ||
                          i_item.request_code == ucrh_pkg::REQ_SET_PROTOCOL)) begin
                n_cmd.handshake = ucrh_pkg::HS_ACK;
                if (i_item.request_code == ucrh_pkg::REQ_SET_IDLE) begin
                    n_idle = i_item.value_word[15:8];
                end else if (i_item.request_code == ucrh_pkg::REQ_SET_PROTOCOL) begin
                    n_proto = i_item.value_word[7:0];
                end
            end
            n_cmd.device_address      = n_addr;
            n_cmd.configuration_value = n_config;
        end else if (r_busy) begin
            // Walk the descriptor table; a hit or the end of it yields a command.
            if (r_slot < 5'(NUM_DESCRIPTORS) && ucrh_pkg::desc_present(r_slot[3:0]) &&
                ent.value == r_req.value_word && ent.index == r_req.index_word) begin
                n_emit = 1'b1;
                if (dlen == 8'd0) begin
                    n_cmd.handshake = ucrh_pkg::HS_ACK;
                end else begin
                    n_cmd.kind      = ucrh_pkg::CMD_DESC;
                    n_cmd.handshake = ucrh_pkg::HS_DATA;
                    n_cmd.desc_base = ent.offset;
                    n_cmd.desc_len  = dlen;
                end
            end else if (r_slot >= 5'(NUM_DESCRIPTORS) ||
                         r_slot == 5'(ucrh_pkg::TABLE_SLOTS - 1)) begin
                n_emit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_config    <= '0;
            r_addr      <= '0;
            r_ctrl      <= '0;
            r_line      <= ucrh_pkg::LINE_CODING_RESET;
            r_idle      <= ucrh_pkg::IDLE_RESET;
            r_proto     <= 8'd1;
            r_halt      <= '0;
            r_keys      <= '0;
            r_busy      <= 1'b0;
            r_slot      <= '0;
            r_cmd_valid <= 1'b0;
        end else begin
            r_config <= n_config;
            r_addr   <= n_addr;
            r_ctrl   <= n_ctrl;
            r_line   <= n_line;
            r_idle   <= n_idle;
            r_proto  <= n_proto;
            r_halt   <= n_halt;
            r_keys   <= n_keys;
            if (i_valid && o_ready && !i_item.action &&
                i_item.request_code == ucrh_pkg::REQ_GET_DESC) begin
                r_busy <= 1'b1;
                r_slot <= '0;
            end else if (r_busy) begin
                if (n_emit) begin
                    r_busy <= 1'b0;
                end else begin
                    r_slot <= r_slot + 5'd1;
                end
            end
            if (n_emit) begin
                r_cmd_valid <= 1'b1;
            end else if (i_cmd_ready) begin
                r_cmd_valid <= 1'b0;
            end
        end
    end

    // A new command is written only when the previous one is taken.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req <= i_item;
        end
        if (n_emit) begin
            r_cmd <= n_cmd;
        end
    end

    // r_ctrl is device state with no read path in this block.
    logic unused_ctrl;
    assign unused_ctrl = ^r_ctrl;

endmodule

// ===== hdl/ucrh_execute.sv =====
// Back part: turns commands into results and streams descriptor data in
// beats of up to eight bytes into a two-entry result queue. Depends on ucrh_pkg.
`timescale 1ns / 1ps
module ucrh_execute (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  ucrh_pkg::t_cmd      i_cmd,
    output logic                o_cmd_ready,
    output logic                o_empty,
    output ucrh_pkg::t_out_item o_item,
    input  logic                i_pop
);

    ucrh_pkg::t_ex_state r_state, n_state;
    ucrh_pkg::t_cmd      r_cmd;
    logic [7:0]          r_sent, n_sent;

    ucrh_pkg::t_out_item q_mem [0:1];
    logic                r_wp, r_rp;
    logic [1:0]          r_cnt;
    logic                push;
    ucrh_pkg::t_out_item beat;
    logic [7:0]          remain;
    logic [3:0]          nbytes;
    logic [8:0]          after;
    logic [63:0]         data;

    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = q_mem[r_rp];

    assign remain = r_cmd.desc_len - r_sent;
    assign nbytes = (remain > 8'd8) ? 4'd8 : remain[3:0];
    assign after  = {1'b0, r_sent} + {5'd0, nbytes};

    always_comb begin
        data = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < nbytes) begin
                data[8*b +: 8] = ucrh_pkg::rom_byte(9'(r_cmd.desc_base) + 9'(r_sent) + 9'(b));
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sent      = r_sent;
        push        = 1'b0;
        o_cmd_ready = 1'b0;
        beat        = '{handshake: i_cmd.handshake, data_bytes: i_cmd.data_bytes,
                        byte_count: i_cmd.byte_count,
                        packet_end: (i_cmd.handshake == ucrh_pkg::HS_DATA),
                        last: 1'b1, device_address: i_cmd.device_address,
                        configuration_value: i_cmd.configuration_value};
        unique case (r_state)
            ucrh_pkg::EX_IDLE: begin
                o_cmd_ready = (r_cnt != 2'd2);
                if (i_cmd_valid && o_cmd_ready) begin
                    if (i_cmd.kind == ucrh_pkg::CMD_DESC) begin
                        n_state = ucrh_pkg::EX_DESC;
                        n_sent  = '0;
                    end else begin
                        push = 1'b1;
                    end
                end
            end
            ucrh_pkg::EX_DESC: begin
                beat.handshake  = ucrh_pkg::HS_DATA;
                beat.data_bytes = data;
                beat.byte_count = nbytes;
                beat.last       = (after >= 9'(r_cmd.desc_len));
                beat.packet_end = beat.last ||
                    ((9'(r_sent) / ucrh_pkg::EP0_PACKET_BYTES) !=
                     (after / ucrh_pkg::EP0_PACKET_BYTES));
                beat.device_address      = r_cmd.device_address;
                beat.configuration_value = r_cmd.configuration_value;
                if (r_cnt != 2'd2) begin
                    push   = 1'b1;
                    n_sent = after[7:0];
                    if (beat.last) begin
                        n_state = ucrh_pkg::EX_IDLE;
                    end
                end
            end
            default: n_state = ucrh_pkg::EX_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ucrh_pkg::EX_IDLE;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_pop && !o_empty) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop && !o_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sent <= n_sent;
        if (i_cmd_valid && o_cmd_ready) begin
            r_cmd <= i_cmd;
        end
        if (push) begin
            q_mem[r_wp] <= beat;
        end
    end

endmodule

// ===== hdl/ucrh_checker.sv =====
// Port-level checker for the request handler, bound to the top level.
// Depends on ucrh_pkg.
`timescale 1ns / 1ps
module ucrh_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                empty,
    input logic                pop,
    input ucrh_pkg::t_out_item o_item
);

    a_stall_hs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.handshake != ucrh_pkg::HS_DATA) |->
        (o_item.byte_count == 4'd0 && o_item.last))
        else $error("non-data request result is not a single final result");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.handshake == ucrh_pkg::HS_DATA) |->
        (o_item.byte_count != 4'd0 && o_item.byte_count <= 4'd8))
        else $error("data beat with bad byte count");

    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.handshake == ucrh_pkg::HS_DATA && o_item.last) |->
        o_item.packet_end)
        else $error("final data beat does not close a packet");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_item)))
        else $error("waiting result changed");

endmodule

bind usb_control_request_handler_top ucrh_checker u_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .empty  (empty),
    .pop    (pop),
    .o_item (o_item)
);

// ===== dv/usb_control_request_handler_checker.sv =====
// Checker for the USB control request handler: watches the request and result
// queues, predicts every result and compares it field by field.
// Depends on ucrh_pkg.
`timescale 1ns / 1ps
module usb_control_request_handler_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_full,
    input  ucrh_pkg::t_in_item  i_item,
    input  logic                i_empty,
    input  logic                i_pop,
    input  ucrh_pkg::t_out_item i_result,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_requests,
    output int                  o_results
);

    localparam int PACKET_BYTES = ucrh_pkg::EP0_PACKET_BYTES;
    localparam int ENDPOINTS    = 4;

    // Device state as the handler should hold it.
    logic [7:0]  cfg_num;
    logic [6:0]  bus_addr;
    logic [55:0] line_code;
    logic [7:0]  idle_val;
    logic [7:0]  protocol_val;
    logic [3:0]  halted;
    logic [47:0] keys;

    ucrh_pkg::t_out_item expected_results[$];

    assign o_pending = expected_results.size();

    function automatic ucrh_pkg::t_out_item make_result(logic [1:0] hs, logic [63:0] data,
                                                        logic [3:0] cnt, logic pend,
                                                        logic fin);
        ucrh_pkg::t_out_item r;
        r.handshake           = hs;
        r.data_bytes          = data;
        r.byte_count          = cnt;
        r.packet_end          = pend;
        r.last                = fin;
        r.device_address      = bus_addr;
        r.configuration_value = cfg_num;
        return r;
    endfunction

    task automatic push_ack();
        expected_results.push_back(make_result(ucrh_pkg::HS_ACK, '0, 4'd0, 1'b0, 1'b1));
    endtask

    task automatic push_stall();
        expected_results.push_back(make_result(ucrh_pkg::HS_STALL, '0, 4'd0, 1'b0, 1'b1));
    endtask

    task automatic push_beat(logic [63:0] data, logic [3:0] cnt);
        expected_results.push_back(make_result(ucrh_pkg::HS_DATA, data, cnt, 1'b1, 1'b1));
    endtask

    task automatic queue_descriptor(logic [15:0] val, logic [15:0] idx,
                                    logic [15:0] wlen);
        int                    slot;
        int                    len;
        int                    sent;
        int                    n;
        int                    base;
        int                    addr;
        logic [63:0]           data;
        ucrh_pkg::t_desc_entry e;
        slot = -1;
        for (int i = 0; i < 8; i++) begin
            e = ucrh_pkg::desc_entry(4'(i));
            if (slot < 0 && e.value == val && e.index == idx) begin
                slot = i;
            end
        end
        if (slot < 0) begin
            push_stall();
            return;
        end
        e = ucrh_pkg::desc_entry(4'(slot));
        len = (wlen < 16'd255) ? int'(wlen) : 255;
        if (int'(e.length) < len) len = int'(e.length);
        if (len == 0) begin
            push_ack();
            return;
        end
        base = int'(e.offset);
        sent = 0;
        while (sent < len) begin
            n = (len - sent > 8) ? 8 : len - sent;
            data = '0;
            for (int b = 0; b < n; b++) begin
                addr = base + sent + b;
                data[8*b +: 8] = (addr < ucrh_pkg::ROM_BYTES) ? ucrh_pkg::ROM[addr] : 8'h00;
            end
            expected_results.push_back(make_result(ucrh_pkg::HS_DATA, data, 4'(n),
                (sent + n >= len) || (sent / PACKET_BYTES != (sent + n) / PACKET_BYTES),
                sent + n >= len));
            sent += n;
        end
    endtask

    task automatic predict_request(ucrh_pkg::t_in_item it);
        int ep;
        ep = int'(it.index_word[6:0]);
        if (it.action) begin
            keys = it.key_report;
            return;
        end
        if (it.request_code == ucrh_pkg::REQ_GET_DESC) begin
            queue_descriptor(it.value_word, it.index_word, it.length_word);
            return;
        end
        if (it.request_code == ucrh_pkg::REQ_SET_ADDRESS) begin
            bus_addr = it.value_word[6:0];
            push_ack();
            return;
        end
        if (it.request_code == ucrh_pkg::REQ_SET_CONFIG &&
                it.request_type == ucrh_pkg::TYPE_STD_DEV_OUT) begin
            cfg_num = it.value_word[7:0];
            halted = '0;
            push_ack();
            return;
        end
        if (it.request_code == ucrh_pkg::REQ_GET_CONFIG &&
                it.request_type == ucrh_pkg::TYPE_STD_DEV_IN) begin
            push_beat(64'(cfg_num), 4'd1);
            return;
        end
        if (it.request_code == ucrh_pkg::REQ_GET_LINE &&
                it.request_type == ucrh_pkg::TYPE_CLASS_IN) begin
            push_beat(64'(line_code), 4'd7);
            return;
        end
        if (it.request_code == ucrh_pkg::REQ_SET_LINE &&
                it.request_type == ucrh_pkg::TYPE_CLASS_OUT) begin
            line_code = it.out_payload;
            push_ack();
            return;
        end
        if (it.request_code == ucrh_pkg::REQ_SET_CTRL &&
                it.request_type == ucrh_pkg::TYPE_CLASS_OUT) begin
            push_ack();
            return;
        end
        if (it.request_code == ucrh_pkg::REQ_GET_STATUS) begin
            logic [63:0] st;
            st = '0;
            if (it.request_type == ucrh_pkg::TYPE_STD_EP_IN && ep >= 1 && ep <= ENDPOINTS) begin
                st[0] = halted[ep-1];
            end
            push_beat(st, 4'd2);
            return;
        end
        if ((it.request_code == ucrh_pkg::REQ_CLEAR_FEATURE ||
                it.request_code == ucrh_pkg::REQ_SET_FEATURE)
                && it.request_type == ucrh_pkg::TYPE_STD_EP_OUT && it.value_word == 16'd0
                && ep >= 1 && ep <= ENDPOINTS) begin
            halted[ep-1] = (it.request_code == ucrh_pkg::REQ_SET_FEATURE);
            push_ack();
            return;
        end
        // Keyboard class requests; everything else stalls.
        if (it.index_word == ucrh_pkg::KBD_INTERFACE) begin
            if (it.request_type == ucrh_pkg::TYPE_CLASS_IN) begin
                case (it.request_code)
                    ucrh_pkg::REQ_CLEAR_FEATURE: begin
                        push_beat({keys, 16'h0000}, 4'd8);
                        return;
                    end
                    ucrh_pkg::REQ_GET_IDLE: begin
                        push_beat(64'(idle_val), 4'd1);
                        return;
                    end
                    ucrh_pkg::REQ_SET_FEATURE: begin
                        push_beat(64'(protocol_val), 4'd1);
                        return;
                    end
                    default: ;
                endcase
            end
            if (it.request_type == ucrh_pkg::TYPE_CLASS_OUT) begin
                case (it.request_code)
                    ucrh_pkg::REQ_SET_CONFIG: begin
                        push_ack();
                        return;
                    end
                    ucrh_pkg::REQ_SET_IDLE: begin
                        idle_val = it.value_word[15:8];
                        push_ack();
                        return;
                    end
                    ucrh_pkg::REQ_SET_PROTOCOL: begin
                        protocol_val = it.value_word[7:0];
                        push_ack();
                        return;
                    end
                    default: ;
                endcase
            end
        end
        push_stall();
    endtask

    always @(posedge i_clk) begin
        ucrh_pkg::t_out_item want;
        if (!i_rst_n) begin
            cfg_num      = '0;
            bus_addr     = '0;
            line_code    = ucrh_pkg::LINE_CODING_RESET;
            idle_val     = ucrh_pkg::IDLE_RESET;
            protocol_val = 8'd1;
            halted       = '0;
            keys         = '0;
            expected_results.delete();
            o_fail_count <= 0;
            o_requests   <= 0;
            o_results    <= 0;
        end else begin
            // The result leaves before the new request is predicted: both are
            // sampled on the same edge and the result was already committed.
            if (i_pop && !i_empty) begin
                o_results <= o_results + 1;
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10) $display("ERROR: unexpected result %p", i_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== i_result) begin
                        if (o_fail_count < 10) begin
                            $display("ERROR: result mismatch at %0t", $realtime);
                            $display("  expected %p", want);
                            $display("  actual   %p", i_result);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_push && !i_full) begin
                o_requests <= o_requests + 1;
                predict_request(i_item);
            end
        end
    end
endmodule

// ===== dv/tb_usb_control_request_handler_top.sv =====
// Testbench top for the USB control request handler: drives requests with
// bursts and gaps, stalls the result side, and reports the verdict.
// Depends on ucrh_pkg, usb_control_request_handler_top and the checker.
`timescale 1ns / 1ps
module tb_usb_control_request_handler_top;

    localparam int RANDOM_REQUESTS = 460;
    localparam int IDLE_LIMIT      = 5000;

    logic                i_clk;
    logic                i_rst_n;
    logic                push;
    logic                full;
    ucrh_pkg::t_in_item  in_item;
    logic                empty;
    logic                pop;
    ucrh_pkg::t_out_item out_item;
    int                  fail_count;
    int                  pending;
    int                  request_count;
    int                  result_count;
    bit                  hold_results;
    int                  idle_cycles;

    usb_control_request_handler_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (in_item),
        .empty   (empty),
        .pop     (pop),
        .o_item  (out_item)
    );

    usb_control_request_handler_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (in_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_requests   (request_count),
        .o_results    (result_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Receiver: its own stall pattern, plus one long hold-off on request.
    initial begin
        int phase;
        pop = 1'b0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            phase++;
            if (hold_results) pop <= 1'b0;
            else if (phase % 64 < 20) pop <= 1'b1;
            else pop <= ($urandom_range(0, 3) != 0);
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_request(ucrh_pkg::t_in_item it);
        push    <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause_sender(int cycles);
        push <= 1'b0;
        in_item <= ucrh_pkg::t_in_item'({$urandom, $urandom, $urandom, $urandom,
                                         $urandom, $urandom});
        repeat (cycles) @(negedge i_clk);
    endtask

    function automatic ucrh_pkg::t_in_item setup_request(logic [7:0] rtype,
                                                         logic [7:0] code,
                                                         logic [15:0] val,
                                                         logic [15:0] idx,
                                                         logic [15:0] wlen);
        ucrh_pkg::t_in_item it;
        it = ucrh_pkg::t_in_item'({$urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom});
        it.action       = 1'b0;
        it.request_type = rtype;
        it.request_code = code;
        it.value_word   = val;
        it.index_word   = idx;
        it.length_word  = wlen;
        return it;
    endfunction

    function automatic ucrh_pkg::t_in_item key_update();
        ucrh_pkg::t_in_item it;
        it = ucrh_pkg::t_in_item'({$urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom});
        it.action = 1'b1;
        return it;
    endfunction

    // Mostly well-formed requests with random fields, some pure noise.
    function automatic ucrh_pkg::t_in_item random_request();
        ucrh_pkg::t_in_item    it;
        ucrh_pkg::t_desc_entry e;
        logic [15:0]           wlen;
        int                    slot;
        wlen = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        slot = $urandom_range(0, 9);
        e = ucrh_pkg::desc_entry(4'(slot));
        case ($urandom_range(0, 15))
            0, 1, 2: begin
                if (slot < 8) begin
                    it = setup_request(8'($urandom), ucrh_pkg::REQ_GET_DESC, e.value,
                                       e.index, wlen);
                end else begin
                    it = setup_request(8'($urandom), ucrh_pkg::REQ_GET_DESC, 16'($urandom),
                                       16'($urandom), wlen);
                end
            end
            3: it = setup_request(8'($urandom), ucrh_pkg::REQ_SET_ADDRESS, 16'($urandom),
                                  16'($urandom), wlen);
            4: it = setup_request(ucrh_pkg::TYPE_STD_DEV_OUT, ucrh_pkg::REQ_SET_CONFIG,
                                  16'($urandom), 16'($urandom), 0);
            5: it = setup_request(ucrh_pkg::TYPE_STD_DEV_IN, ucrh_pkg::REQ_GET_CONFIG,
                                  0, 0, wlen);
            6: it = setup_request(ucrh_pkg::TYPE_CLASS_IN, ucrh_pkg::REQ_GET_LINE, 0, 0, wlen);
            7: it = setup_request(ucrh_pkg::TYPE_CLASS_OUT, ucrh_pkg::REQ_SET_LINE, 0, 0, 7);
            8: it = setup_request(ucrh_pkg::TYPE_CLASS_OUT, ucrh_pkg::REQ_SET_CTRL,
                                  16'($urandom), 0, 0);
            9: it = setup_request($urandom_range(0, 1) ? ucrh_pkg::TYPE_STD_EP_IN
                                                       : 8'($urandom),
                                  ucrh_pkg::REQ_GET_STATUS, 0, {8'($urandom), 1'($urandom),
                                  7'($urandom_range(0, 6))}, 2);
            10: it = setup_request(ucrh_pkg::TYPE_STD_EP_OUT,
                                   $urandom_range(0, 1) ? ucrh_pkg::REQ_SET_FEATURE
                                                        : ucrh_pkg::REQ_CLEAR_FEATURE,
                                   ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'h0,
                                   {8'($urandom), 1'($urandom), 7'($urandom_range(0, 6))}, 0);
            11, 12: begin
                it = setup_request($urandom_range(0, 1) ? ucrh_pkg::TYPE_CLASS_IN
                                                        : ucrh_pkg::TYPE_CLASS_OUT,
                                   8'($urandom_range(1, 11)), 16'($urandom),
                                   ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                               : ucrh_pkg::KBD_INTERFACE,
                                   wlen);
            end
            13: it = key_update();
            default: begin
                it = ucrh_pkg::t_in_item'({$urandom, $urandom, $urandom, $urandom,
                                           $urandom, $urandom});
                it.action = 1'b0;
            end
        endcase
        return it;
    endfunction

    initial begin
        ucrh_pkg::t_in_item it;
        int                 burst;
        i_rst_n      = 1'b0;
        push         = 1'b0;
        in_item      = '0;
        hold_results = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: every request kind and the corner cases.
        send_request(setup_request(ucrh_pkg::TYPE_STD_DEV_IN, ucrh_pkg::REQ_GET_STATUS,
                                   0, 0, 2));
        send_request(setup_request(ucrh_pkg::TYPE_STD_DEV_IN, ucrh_pkg::REQ_GET_DESC,
                                   16'h0100, 0, 16'hFFFF));
        send_request(setup_request(ucrh_pkg::TYPE_STD_DEV_IN, ucrh_pkg::REQ_GET_DESC,
                                   16'h0200, 0, 16'hFFFF));
        send_request(setup_request(ucrh_pkg::TYPE_STD_DEV_IN, ucrh_pkg::REQ_GET_DESC,
                                   16'h2200, 2, 16'd17));
        send_request(setup_request(ucrh_pkg::TYPE_STD_DEV_IN, ucrh_pkg::REQ_GET_DESC,
                                   16'h0302, 16'h0409, 0));
        send_request(setup_request(ucrh_pkg::TYPE_STD_DEV_IN, ucrh_pkg::REQ_GET_DESC,
                                   16'hFFFF, 16'hFFFF, 64));
        send_request(setup_request(ucrh_pkg::TYPE_STD_DEV_OUT, ucrh_pkg::REQ_SET_ADDRESS,
                                   16'hFFFF, 0, 0));
        send_request(setup_request(ucrh_pkg::TYPE_STD_DEV_OUT, ucrh_pkg::REQ_SET_CONFIG,
                                   16'h00FF, 0, 0));
        send_request(setup_request(ucrh_pkg::TYPE_STD_DEV_IN, ucrh_pkg::REQ_GET_CONFIG,
                                   0, 0, 0));
        send_request(setup_request(ucrh_pkg::TYPE_CLASS_IN, ucrh_pkg::REQ_GET_LINE, 0, 0, 0));
        it = setup_request(ucrh_pkg::TYPE_CLASS_OUT, ucrh_pkg::REQ_SET_LINE, 0, 0, 7);
        it.out_payload = '1;
        send_request(it);
        send_request(setup_request(ucrh_pkg::TYPE_CLASS_IN, ucrh_pkg::REQ_GET_LINE, 0, 0, 7));
        send_request(setup_request(ucrh_pkg::TYPE_CLASS_OUT, ucrh_pkg::REQ_SET_CTRL,
                                   16'h0003, 0, 0));
        send_request(setup_request(ucrh_pkg::TYPE_STD_EP_OUT, ucrh_pkg::REQ_SET_FEATURE,
                                   0, 16'h0084, 0));
        send_request(setup_request(ucrh_pkg::TYPE_STD_EP_IN, ucrh_pkg::REQ_GET_STATUS,
                                   0, 16'h0084, 2));
        send_request(setup_request(ucrh_pkg::TYPE_STD_EP_OUT, ucrh_pkg::REQ_SET_FEATURE,
                                   0, 16'h0005, 0));
        send_request(setup_request(ucrh_pkg::TYPE_STD_EP_OUT, ucrh_pkg::REQ_CLEAR_FEATURE,
                                   0, 16'h0002, 0));
        it = key_update();
        it.key_report = '1;
        send_request(it);
        send_request(setup_request(ucrh_pkg::TYPE_CLASS_IN, ucrh_pkg::REQ_CLEAR_FEATURE,
                                   0, ucrh_pkg::KBD_INTERFACE, 8));
        send_request(setup_request(ucrh_pkg::TYPE_CLASS_OUT, ucrh_pkg::REQ_SET_IDLE,
                                   16'hFF00, ucrh_pkg::KBD_INTERFACE, 0));
        send_request(setup_request(ucrh_pkg::TYPE_CLASS_IN, ucrh_pkg::REQ_GET_IDLE,
                                   0, ucrh_pkg::KBD_INTERFACE, 1));
        send_request(setup_request(ucrh_pkg::TYPE_CLASS_OUT, ucrh_pkg::REQ_SET_PROTOCOL,
                                   16'h0000, ucrh_pkg::KBD_INTERFACE, 0));
        send_request(setup_request(ucrh_pkg::TYPE_CLASS_IN, ucrh_pkg::REQ_SET_FEATURE,
                                   0, ucrh_pkg::KBD_INTERFACE, 1));
        send_request(setup_request(ucrh_pkg::TYPE_CLASS_OUT, ucrh_pkg::REQ_SET_CONFIG,
                                   0, ucrh_pkg::KBD_INTERFACE, 8));
        send_request(setup_request(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

        // Drain completely once before random traffic.
        pause_sender(1);
        while (pending != 0) @(negedge i_clk);

        // Long result hold-off while the sender keeps offering requests.
        fork
            begin
                hold_results = 1'b1;
                repeat (300) @(negedge i_clk);
                hold_results = 1'b0;
            end
        join_none

        for (int n = 0; n < RANDOM_REQUESTS; ) begin
            burst = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            for (int k = 0; k < burst && n < RANDOM_REQUESTS; k++, n++) begin
                send_request(random_request());
            end
            if (burst == 0 || $urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 30));
            if (n > RANDOM_REQUESTS / 2 && n < RANDOM_REQUESTS / 2 + 13) begin
                pause_sender(1);
                while (pending != 0) @(negedge i_clk);
            end
        end
        push <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        $display("Sent %0d requests and checked %0d results, covering every request kind,",
                 request_count, result_count);
        $display("descriptor lengths from zero to full, stalls, and full-queue back-pressure.");
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("ERROR: %0d mismatches, %0d results still owed", fail_count, pending);
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
